// ===== src/brr_pkg.sv =====
// Shared constants and types for the byte ring with reserve.
// No dependencies; imported by brr_front, brr_back and the top level.
package brr_pkg;

	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 64;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int BYTE_W = 8;
	localparam int AMT_W  = 7;
	localparam int SLOT_W = 6;
	// wide enough for tail + amount and for every count compare
	localparam int CMP_W  = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 1;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_RESERVE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data_byte;
		logic [AMT_W-1:0]  amount;
		logic [AMT_W-1:0]  pop_cap;   // amount limited to MAX_RESULTS
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic              byte_valid;
		logic [BYTE_W-1:0] out_byte;
		logic [SLOT_W-1:0] slot_position;
		logic [AMT_W-1:0]  moved_total;
		logic              last;
	} res_t;

endpackage

// ===== src/brr_in_if.sv =====
// Input channel of the byte ring: valid/ready plus the item fields.
// Depends on nothing.
interface brr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [6:0] amount;

	modport source (output valid, output operation, output data_byte, output amount,
		input ready);
	modport sink (input valid, input operation, input data_byte, input amount,
		output ready);
endinterface

// ===== src/brr_out_if.sv =====
// Result channel of the byte ring: valid/ready plus the result fields.
// Depends on nothing.
interface brr_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic [5:0] slot_position;
	logic [6:0] moved_total;
	logic       last;

	modport source (output valid, output status, output byte_valid, output out_byte,
		output slot_position, output moved_total, output last, input ready);
	modport sink (input valid, input status, input byte_valid, input out_byte,
		input slot_position, input moved_total, input last, output ready);
endinterface

// ===== src/brr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/brr_front.sv =====
// Front end: accepts items, decodes the operation, caps the pop count and
// holds decoded commands in a two-entry queue. Depends on brr_pkg, brr_in_if.
module brr_front import brr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	brr_in_if.sink     cmd,
	output logic       cmd_valid,
	output cmd_t       cmd_head,
	input  logic       cmd_take
);

	cmd_t       q_mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       dec;

	assign cmd.ready = (cnt_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_head  = q_mem[rd_q];

	always_comb begin
		dec.op        = op_t'(cmd.operation);
		dec.data_byte = cmd.data_byte;
		dec.amount    = cmd.amount;
		if (CMP_W'(cmd.amount) > CMP_W'(MAX_RESULTS)) begin
			dec.pop_cap = AMT_W'(MAX_RESULTS);
		end else begin
			dec.pop_cap = cmd.amount;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end

endmodule

// ===== src/brr_back.sv =====
// Back end: owns the ring state, carries out commands against the storage
// RAM and queues results. Depends on brr_pkg, brr_ram, brr_out_if.
module brr_back import brr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd_head,
	output logic       cmd_take,
	brr_out_if.source  res
);

	typedef enum logic {ST_CMD, ST_POP} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    front_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CAPACITY-1:0] vld_q;
	logic [AMT_W-1:0]    todo_q;
	logic [AMT_W-1:0]    moved_q;

	logic                s1_valid;
	res_t                res_s1;
	logic                rdv_s1;

	// result queue
	res_t                rq_mem [4];
	logic [1:0]          rq_wr_q;
	logic [1:0]          rq_rd_q;
	logic [2:0]          rq_cnt_q;
	logic                rq_deq;

	logic                can_issue;
	logic [CNT_W:0]      tail_sum;
	logic [IDX_W-1:0]    tail;
	logic                full;
	logic [CMP_W-1:0]    amt_x;
	logic [CMP_W-1:0]    fill_x;
	logic [CMP_W-1:0]    todo_x;
	logic                rsv_ok;
	logic [IDX_W-1:0]    front_inc;
	logic [AMT_W-1:0]    moved_nxt;
	logic                pop_last;
	logic                ram_we;
	logic [BYTE_W-1:0]   ram_rdata;
	res_t                rq_entry;

	brr_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail),
		.wdata (cmd_head.data_byte),
		.raddr (front_q),
		.rdata (ram_rdata)
	);

	// keep room for the item in s1 plus the one issued now
	assign can_issue = ({1'b0, rq_cnt_q} + {3'b0, s1_valid}) < 4'd3;
	assign cmd_take  = (state_q == ST_CMD) && cmd_valid && can_issue;

	always_comb begin
		tail_sum = (CNT_W+1)'(front_q) + (CNT_W+1)'(fill_q);
		if (tail_sum >= (CNT_W+1)'(CAPACITY)) begin
			tail = IDX_W'(tail_sum - (CNT_W+1)'(CAPACITY));
		end else begin
			tail = IDX_W'(tail_sum);
		end
		full   = (fill_q == CNT_W'(CAPACITY));
		amt_x  = CMP_W'(cmd_head.amount);
		fill_x = CMP_W'(fill_q);
		rsv_ok = (amt_x <= CMP_W'(CAPACITY) - fill_x)
			&& (CMP_W'(tail) + amt_x <= CMP_W'(CAPACITY));
		if (CMP_W'(cmd_head.pop_cap) > fill_x) begin
			todo_x = fill_x;
		end else begin
			todo_x = CMP_W'(cmd_head.pop_cap);
		end
		if (front_q == IDX_W'(CAPACITY - 1)) begin
			front_inc = '0;
		end else begin
			front_inc = front_q + 1'b1;
		end
		moved_nxt = moved_q + 1'b1;
		pop_last  = (moved_nxt == todo_q);
		ram_we    = cmd_take && (cmd_head.op == OP_PUSH) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CMD;
			front_q  <= '0;
			fill_q   <= '0;
			vld_q    <= '0;
			todo_q   <= '0;
			moved_q  <= '0;
			s1_valid <= 1'b0;
			res_s1   <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			s1_valid <= 1'b0;
			unique case (state_q)
				ST_CMD: begin
					if (cmd_take) begin
						s1_valid <= 1'b1;
						rdv_s1   <= 1'b0;
						res_s1   <= '0;
						res_s1.last <= 1'b1;
						unique case (cmd_head.op)
							OP_PUSH: begin
								res_s1.status <= full;
								if (!full) begin
									vld_q[tail] <= 1'b1;
									fill_q      <= fill_q + 1'b1;
								end
							end
							OP_RESERVE: begin
								res_s1.status <= !rsv_ok;
								if (rsv_ok) begin
									fill_q <= CNT_W'(fill_x + amt_x);
									res_s1.slot_position <= SLOT_W'(tail);
								end
							end
							OP_POP: begin
								if (todo_x != '0) begin
									// bytes go out from ST_POP, no result here
									s1_valid <= 1'b0;
									todo_q   <= AMT_W'(todo_x);
									moved_q  <= '0;
									state_q  <= ST_POP;
								end
							end
							OP_CLEAR: begin
								vld_q   <= '0;
								front_q <= '0;
								fill_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_POP: begin
					if (can_issue) begin
						s1_valid <= 1'b1;
						rdv_s1   <= vld_q[front_q];
						res_s1   <= '0;
						res_s1.byte_valid  <= 1'b1;
						res_s1.moved_total <= moved_nxt;
						res_s1.last        <= pop_last;
						moved_q <= moved_nxt;
						front_q <= front_inc;
						fill_q  <= fill_q - 1'b1;
						if (pop_last) begin
							state_q <= ST_CMD;
						end
					end
				end
				default: state_q <= ST_CMD;
			endcase
		end
	end

	// entries never written since reset or clear read as zero
	always_comb begin
		rq_entry = res_s1;
		if (res_s1.byte_valid && rdv_s1) begin
			rq_entry.out_byte = ram_rdata;
		end else begin
			rq_entry.out_byte = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			rq_mem[rq_wr_q] <= rq_entry;
		end
	end

	assign rq_deq = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (s1_valid) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (rq_deq) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			rq_cnt_q <= rq_cnt_q + {2'b0, s1_valid} - {2'b0, rq_deq};
		end
	end

	assign res.valid         = (rq_cnt_q != 3'd0);
	assign res.status        = rq_mem[rq_rd_q].status;
	assign res.byte_valid    = rq_mem[rq_rd_q].byte_valid;
	assign res.out_byte      = rq_mem[rq_rd_q].out_byte;
	assign res.slot_position = rq_mem[rq_rd_q].slot_position;
	assign res.moved_total   = rq_mem[rq_rd_q].moved_total;
	assign res.last          = rq_mem[rq_rd_q].last;

endmodule

// ===== src/byte_ring_with_reserve_unit.sv =====
// Top level of the byte ring with reserve: front end, back end and storage.
// Depends on brr_pkg, brr_in_if, brr_out_if, brr_front, brr_back.
//
// Usage:
//   cmd carries items (operation, data_byte, amount) under valid/ready;
//   res returns result items under valid/ready, last set on the final
//   result of each item.
//   Push, reserve, clear and an empty pop give one result, which passes
//   through the s1 register and the result queue; one such item can be
//   taken per cycle while the result queue has room. A pop that moves
//   bytes first sets up in the back end, then gives one byte per cycle from
//   the storage RAM's registered read port while the result queue has room; it moves at most 64 bytes.
//   A two-entry command queue lets the front keep accepting while the back
//   works; a four-entry result queue decouples the receiver.
//   When res is stalled the back end stops issuing once the result queue
//   is nearly full; cmd.ready drops when the command queue fills.
//   Reset (arst_n low) empties the ring and marks every byte as zero;
//   a clear item does the same through per-byte valid flags.
module byte_ring_with_reserve_unit import brr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	brr_in_if.sink    cmd,
	brr_out_if.source res
);

	logic cmd_valid;
	cmd_t cmd_head;
	logic cmd_take;

	brr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_take  (cmd_take)
	);

	brr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_take  (cmd_take),
		.res       (res)
	);

endmodule
